### design/gls_pkg.sv
// Shared widths, register indexes, cost codes and controller/datapath interface types.
package gls_pkg;

  localparam int unsigned COORD_W   = 8;
  localparam int unsigned COST_W    = 8;
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COST_NEUTRAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COST_FACTOR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_UNKNOWN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHEAP_THRESHOLD = 3'd5;

  localparam logic [SIZE_W-1:0] RST_GRID_SIZE       = 9'd256;
  localparam logic [COST_W-1:0] RST_COST_NEUTRAL    = 8'd50;
  localparam logic [COST_W-1:0] RST_COST_FACTOR     = 8'd205;
  localparam logic [COST_W-1:0] RST_CHEAP_THRESHOLD = 8'd150;

  localparam logic [COST_W-1:0] COST_CAP     = 8'd253;
  localparam logic [COST_W-1:0] COST_LETHAL  = 8'd254;
  localparam logic [COST_W-1:0] COST_UNKNOWN = 8'd255;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    PROBE_DIAG,
    PROBE_SIDE,
    PROBE_SIDE_LOW
  } probe_sel_e;

  typedef struct packed {
    logic       accept;
    logic       init;
    logic       write_cell;
    logic       clr_en;
    logic       read_en;
    probe_sel_e probe_sel;
    logic       step_minor;
    logic       acc_add;
    logic       adv_major;
    logic       latch_a;
    logic       finish;
    logic       finish_clear;
  } gls_cmd_t;

  typedef struct packed {
    logic at_end;
    logic axis;
    logic diag;
    logic need2;
    logic cheap;
    logic a_cheap;
    logic clr_last;
  } gls_status_t;

endpackage

### design/gls_ram.sv
// Generic single-port RAM with registered read data.
module gls_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 256,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/gls_ctrl.sv
// Controller state machine: clearing pass, write, and line walk sequencing.
module gls_ctrl import gls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        req_type_i,
  input  gls_status_t status_i,
  output gls_cmd_t    cmd_o,
  output logic        busy_o
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_WRITE = 4'd2;
  localparam logic [3:0] ST_INIT  = 4'd3;
  localparam logic [3:0] ST_STEP  = 4'd4;
  localparam logic [3:0] ST_CHK1  = 4'd5;
  localparam logic [3:0] ST_CHK2  = 4'd6;
  localparam logic [3:0] ST_AX1   = 4'd7;
  localparam logic [3:0] ST_AX2   = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d = (req_type_i == REQ_QUERY) ? ST_INIT : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write_cell = 1'b1;
        cmd_o.finish     = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_STEP;
      end
      ST_STEP: begin
        if (status_i.at_end) begin
          cmd_o.finish       = 1'b1;
          cmd_o.finish_clear = 1'b1;
          state_d            = ST_IDLE;
        end else if (status_i.axis) begin
          cmd_o.read_en   = 1'b1;
          cmd_o.probe_sel = PROBE_SIDE;
          state_d         = ST_AX1;
        end else if (status_i.diag) begin
          cmd_o.read_en    = 1'b1;
          cmd_o.probe_sel  = PROBE_DIAG;
          cmd_o.step_minor = 1'b1;
          state_d          = ST_CHK1;
        end else begin
          cmd_o.read_en   = 1'b1;
          cmd_o.probe_sel = PROBE_DIAG;
          cmd_o.acc_add   = 1'b1;
          state_d         = ST_CHK2;
        end
      end
      ST_CHK1: begin
        if (!status_i.cheap) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else if (status_i.need2) begin
          cmd_o.read_en   = 1'b1;
          cmd_o.probe_sel = PROBE_DIAG;
          state_d         = ST_CHK2;
        end else begin
          cmd_o.adv_major = 1'b1;
          state_d         = ST_STEP;
        end
      end
      ST_CHK2: begin
        if (!status_i.cheap) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.adv_major = 1'b1;
          state_d         = ST_STEP;
        end
      end
      ST_AX1: begin
        cmd_o.latch_a   = 1'b1;
        cmd_o.read_en   = 1'b1;
        cmd_o.probe_sel = PROBE_SIDE_LOW;
        state_d         = ST_AX2;
      end
      ST_AX2: begin
        if (!status_i.a_cheap && !status_i.cheap) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.adv_major = 1'b1;
          state_d         = ST_STEP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### design/gls_dp.sv
// Datapath: configuration registers, cost conversion, line walk registers and cost grid.
module gls_dp import gls_pkg::*; #(
  parameter int unsigned GRID_DIM_X = 256,
  parameter int unsigned GRID_DIM_Y = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 req_type_i,
  input  logic [COORD_W-1:0]   cell_x_i,
  input  logic [COORD_W-1:0]   cell_y_i,
  input  logic [COST_W-1:0]    raw_cost_i,
  input  logic [COORD_W-1:0]   from_x_i,
  input  logic [COORD_W-1:0]   from_y_i,
  input  logic [COORD_W-1:0]   to_x_i,
  input  logic [COORD_W-1:0]   to_y_i,
  input  gls_cmd_t             cmd_i,
  output gls_status_t          status_o,
  output logic                 resp_valid_o,
  output logic                 resp_kind_o,
  output logic                 line_clear_o
);

  localparam int unsigned COORD_SPAN = 1 << COORD_W;
  localparam int unsigned MEM_X = (GRID_DIM_X < COORD_SPAN) ? GRID_DIM_X : COORD_SPAN;
  localparam int unsigned MEM_Y = (GRID_DIM_Y < COORD_SPAN) ? GRID_DIM_Y : COORD_SPAN;
  localparam int unsigned XB    = $clog2(MEM_X);
  localparam int unsigned YB    = $clog2(MEM_Y);
  localparam int unsigned AW    = XB + YB;
  localparam int unsigned DEPTH = 1 << AW;

  // configuration
  logic [SIZE_W-1:0] width_q, height_q;
  logic [COST_W-1:0] neutral_q, factor_q, thr_q;
  logic              allow_unk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= RST_GRID_SIZE;
      height_q    <= RST_GRID_SIZE;
      neutral_q   <= RST_COST_NEUTRAL;
      factor_q    <= RST_COST_FACTOR;
      allow_unk_q <= 1'b0;
      thr_q       <= RST_CHEAP_THRESHOLD;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRID_WIDTH:      width_q     <= cfg_data_i;
        REG_GRID_HEIGHT:     height_q    <= cfg_data_i;
        REG_COST_NEUTRAL:    neutral_q   <= cfg_data_i[COST_W-1:0];
        REG_COST_FACTOR:     factor_q    <= cfg_data_i[COST_W-1:0];
        REG_ALLOW_UNKNOWN:   allow_unk_q <= cfg_data_i[0];
        REG_CHEAP_THRESHOLD: thr_q       <= cfg_data_i[COST_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] eff_w, eff_h;
  assign eff_w = ({{(32-SIZE_W){1'b0}}, width_q} > 32'(GRID_DIM_X)) ?
                 SIZE_W'(GRID_DIM_X) : width_q;
  assign eff_h = ({{(32-SIZE_W){1'b0}}, height_q} > 32'(GRID_DIM_Y)) ?
                 SIZE_W'(GRID_DIM_Y) : height_q;

  // request capture
  logic               req_type_q;
  logic [COORD_W-1:0] cx_q, cy_q, fx_q, fy_q, tx_q, ty_q;
  logic [COST_W-1:0]  raw_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_type_q <= req_type_i;
      cx_q       <= cell_x_i;
      cy_q       <= cell_y_i;
      raw_q      <= raw_cost_i;
      fx_q       <= from_x_i;
      fy_q       <= from_y_i;
      tx_q       <= to_x_i;
      ty_q       <= to_y_i;
    end
  end

  // cost conversion
  logic [2*COST_W-1:0] prod;
  logic [COST_W:0]     conv_sum;
  logic [COST_W-1:0]   conv_cost;

  always_comb begin
    prod     = factor_q * raw_q;
    conv_sum = {1'b0, neutral_q} + {1'b0, prod[2*COST_W-1:COST_W]};
    if (raw_q < COST_CAP) begin
      conv_cost = (conv_sum > {1'b0, COST_CAP}) ? COST_CAP : conv_sum[COST_W-1:0];
    end else if ((raw_q == COST_UNKNOWN) && allow_unk_q) begin
      conv_cost = COST_UNKNOWN;
    end else begin
      conv_cost = COST_LETHAL;
    end
  end

  logic in_store;
  assign in_store = ({{(32-COORD_W){1'b0}}, cx_q} < 32'(GRID_DIM_X)) &&
                    ({{(32-COORD_W){1'b0}}, cy_q} < 32'(GRID_DIM_Y));

  // line setup
  logic               dx_neg, dy_neg, swap_n;
  logic [COORD_W-1:0] adx, ady;

  always_comb begin
    dx_neg = (tx_q < fx_q);
    dy_neg = (ty_q < fy_q);
    adx    = dx_neg ? (fx_q - tx_q) : (tx_q - fx_q);
    ady    = dy_neg ? (fy_q - ty_q) : (ty_q - fy_q);
    swap_n = (ady > adx);
  end

  logic               swap_q, smaj_neg_q, smin_neg_q, need2_q, a_cheap_q, inb_q;
  logic [COORD_W-1:0] maj_q, min_q, maj_end_q, dmaj_q, dmin_q, acc_q;
  logic [COORD_W:0]   acc_sum, acc_rem;

  assign acc_sum = {1'b0, acc_q} + {1'b0, dmin_q};
  assign acc_rem = acc_sum - {1'b0, dmaj_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      swap_q     <= swap_n;
      maj_q      <= swap_n ? fy_q : fx_q;
      min_q      <= swap_n ? fx_q : fy_q;
      maj_end_q  <= swap_n ? ty_q : tx_q;
      dmaj_q     <= swap_n ? ady : adx;
      dmin_q     <= swap_n ? adx : ady;
      smaj_neg_q <= swap_n ? dy_neg : dx_neg;
      smin_neg_q <= swap_n ? dx_neg : dy_neg;
      acc_q      <= '0;
    end else begin
      if (cmd_i.step_minor) begin
        min_q   <= smin_neg_q ? (min_q - 1'b1) : (min_q + 1'b1);
        acc_q   <= acc_rem[COORD_W-1:0];
        need2_q <= (acc_rem[COORD_W-1:0] != '0);
      end else if (cmd_i.acc_add) begin
        acc_q <= acc_sum[COORD_W-1:0];
      end
      if (cmd_i.adv_major) begin
        maj_q <= smaj_neg_q ? (maj_q - 1'b1) : (maj_q + 1'b1);
      end
    end
  end

  // probe cell
  logic [COORD_W:0] pmaj, pmin, px, py;
  logic             inb_d;

  always_comb begin
    pmaj = {1'b0, maj_q} - {{COORD_W{1'b0}}, smaj_neg_q};
    case (cmd_i.probe_sel)
      PROBE_DIAG:     pmin = {1'b0, min_q} - {{COORD_W{1'b0}}, smin_neg_q};
      PROBE_SIDE:     pmin = {1'b0, min_q};
      PROBE_SIDE_LOW: pmin = {1'b0, min_q} - {{COORD_W{1'b0}}, 1'b1};
      default:        pmin = {1'b0, min_q};
    endcase
    px    = swap_q ? pmin : pmaj;
    py    = swap_q ? pmaj : pmin;
    inb_d = !px[COORD_W] && (px[COORD_W-1:0] != '0) && (px < eff_w) &&
            !py[COORD_W] && (py[COORD_W-1:0] != '0) && (py < eff_h);
  end

  // grid memory
  logic [AW-1:0]     clr_cnt_q, ram_addr;
  logic [COST_W-1:0] ram_wdata, ram_rdata;
  logic              ram_en, ram_we, cheap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_comb begin
    if (cmd_i.clr_en) begin
      ram_addr = clr_cnt_q;
    end else if (cmd_i.write_cell) begin
      ram_addr = {cy_q[YB-1:0], cx_q[XB-1:0]};
    end else begin
      ram_addr = {py[YB-1:0], px[XB-1:0]};
    end
    ram_we    = cmd_i.clr_en || (cmd_i.write_cell && in_store);
    ram_en    = cmd_i.clr_en || cmd_i.write_cell || cmd_i.read_en;
    ram_wdata = cmd_i.clr_en ? '0 : conv_cost;
  end

  gls_ram #(
    .DATA_W (COST_W),
    .DEPTH  (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_en) begin
      inb_q <= inb_d;
    end
    if (cmd_i.latch_a) begin
      a_cheap_q <= cheap;
    end
  end

  assign cheap = inb_q && (ram_rdata < thr_q);

  // result beat
  logic resp_valid_q, resp_kind_q, line_clear_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_valid_q <= 1'b0;
    end else begin
      resp_valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      resp_kind_q  <= req_type_q;
      line_clear_q <= cmd_i.finish_clear;
    end
  end

  assign resp_valid_o = resp_valid_q;
  assign resp_kind_o  = resp_kind_q;
  assign line_clear_o = line_clear_q;

  assign status_o.at_end   = (maj_q == maj_end_q);
  assign status_o.axis     = (dmin_q == '0);
  assign status_o.diag     = (acc_sum >= {1'b0, dmaj_q});
  assign status_o.need2    = need2_q;
  assign status_o.cheap    = cheap;
  assign status_o.a_cheap  = a_cheap_q;
  assign status_o.clr_last = &clr_cnt_q;

endmodule

### design/grid_line_of_sight.sv
// Top level of the grid line-of-sight block: cost grid writes and line queries.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  request  | start_i, busy_o           | req_type_i, cell_x/y_i, raw_cost_i,
//           |                           | from_x/y_i, to_x/y_i
//  result   | resp_valid_o (strobe)     | resp_kind_o, line_clear_o
//  config   | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A write is done in the write state that follows acceptance and raises the registered result strobe.
// A query walks the line one step along the longer axis at a time, reading one or two grid cells
// per step, and raises the strobe at the end point; a blocked cell ends it early.
// After reset a clearing pass zeroes all 2^(clog2(min(GRID_DIM_X,256)) + clog2(min(GRID_DIM_Y,256)))
// grid entries (65536 by default), one entry per cycle;
// busy_o stays high meanwhile while configuration beats are still taken.
// busy_o falls as the strobe rises; the strobe lasts one cycle and cannot be stalled.
module grid_line_of_sight import gls_pkg::*; #(
  parameter int unsigned GRID_DIM_X = 256,
  parameter int unsigned GRID_DIM_Y = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 req_type_i,
  input  logic [COORD_W-1:0]   cell_x_i,
  input  logic [COORD_W-1:0]   cell_y_i,
  input  logic [COST_W-1:0]    raw_cost_i,
  input  logic [COORD_W-1:0]   from_x_i,
  input  logic [COORD_W-1:0]   from_y_i,
  input  logic [COORD_W-1:0]   to_x_i,
  input  logic [COORD_W-1:0]   to_y_i,
  output logic                 resp_valid_o,
  output logic                 resp_kind_o,
  output logic                 line_clear_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  gls_cmd_t    cmd;
  gls_status_t status;

  assign cfg_ready_o = 1'b1;

  gls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  gls_dp #(
    .GRID_DIM_X (GRID_DIM_X),
    .GRID_DIM_Y (GRID_DIM_Y)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_type_i   (req_type_i),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .raw_cost_i   (raw_cost_i),
    .from_x_i     (from_x_i),
    .from_y_i     (from_y_i),
    .to_x_i       (to_x_i),
    .to_y_i       (to_y_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .resp_valid_o (resp_valid_o),
    .resp_kind_o  (resp_kind_o),
    .line_clear_o (line_clear_o)
  );

endmodule

### design/gls_checker.sv
// Port-level checker for the grid line-of-sight block, bound to the top level.
module gls_checker import gls_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic resp_valid_o,
  input logic resp_kind_o,
  input logic line_clear_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after an accepted request beat");

  a_resp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o |-> !busy_o)
    else $error("result beat while still busy");

  a_resp_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o |=> !resp_valid_o)
    else $error("result strobe longer than one cycle");

  a_write_not_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && (resp_kind_o == REQ_WRITE) |-> !line_clear_o)
    else $error("write result reports a clear line");

endmodule

bind grid_line_of_sight gls_checker u_gls_checker (.*);
